FILE: hw/rtl/sbds_pkg.sv
// ----------------------------------------------------------------------------
// Serial bit-rate divider search package
// Shared types, widths and constants of the divider search block.
// ----------------------------------------------------------------------------
package sbds_pkg;

  localparam int unsigned CODE_W           = 4;
  localparam int unsigned RATE_W           = 32;
  localparam int unsigned REM_W            = 4;
  localparam int unsigned DIV_STEPS        = RATE_W;
  localparam int unsigned STEP_CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int unsigned PRESCALE_MAX_DEF = 7;
  localparam int unsigned DIV_EXP_MAX_DEF  = 8;
  localparam logic [RATE_W-1:0] GAP_INIT   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] clock_rate;
    logic [31:0] target_rate;
  } sbds_in_t;

  typedef struct packed {
    logic [2:0]  prescaler_code;
    logic [3:0]  divider_code;
    logic [30:0] achieved_rate;
  } sbds_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_SCAN,
    ST_FINISH
  } sbds_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic scan;
    logic next_p;
    logic out_load;
  } sbds_cmd_t;

  typedef struct packed {
    logic div_done;
    logic gap_zero;
    logic d_last;
    logic p_last;
  } sbds_sts_t;

endpackage

FILE: hw/rtl/sbds_ctrl.sv
// ----------------------------------------------------------------------------
// Divider search controller
// Sequences the division for each prescaler and the scan over exponents.
// ----------------------------------------------------------------------------
module sbds_ctrl
  import sbds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sbds_sts_t sts_i,
  output sbds_cmd_t cmd_o
);

  sbds_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.gap_zero) begin
          state_d = ST_FINISH;
        end else if (sts_i.d_last) begin
          state_d = sts_i.p_last ? ST_FINISH : ST_START;
        end
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:   cmd_o.load = in_valid_i;
      ST_START:  cmd_o.div_start = 1'b1;
      ST_DIV:    cmd_o = '0;
      ST_SCAN: begin
        cmd_o.scan   = !sts_i.gap_zero;
        cmd_o.next_p = !sts_i.gap_zero && sts_i.d_last && !sts_i.p_last;
      end
      ST_FINISH: cmd_o.out_load = out_free;
      default:   cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/sbds_datapath.sv
// ----------------------------------------------------------------------------
// Divider search datapath
// Bit-serial division by the prescaler, exponent scan and best-fit tracking.
// ----------------------------------------------------------------------------
module sbds_datapath
  import sbds_pkg::*;
#(
  parameter int unsigned PrescaleMax = PRESCALE_MAX_DEF,
  parameter int unsigned DivExpMax   = DIV_EXP_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sbds_in_t  in_data_i,
  input  sbds_cmd_t cmd_i,
  output sbds_sts_t sts_o,
  output sbds_out_t out_data_o
);

  logic [RATE_W-1:0]     clock_q, target_q;
  logic [RATE_W-1:0]     dvd_q, dvd_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [CODE_W-1:0]     p_q, p_d, d_q, d_d;
  logic [CODE_W-1:0]     best_p_q, best_d_q;
  logic [RATE_W-1:0]     min_gap_q, best_rate_q, last_rate_q;
  logic                  found_q;
  sbds_out_t             out_q;

  logic [REM_W:0]        trial, divisor, diff;
  logic                  ge;
  logic [CODE_W:0]       shamt;
  logic [RATE_W-1:0]     rate, gap;
  logic                  take;

  // One quotient bit per cycle; the divisor never exceeds sixteen.
  always_comb begin
    trial   = {rem_q, dvd_q[RATE_W-1]};
    divisor = {1'b0, p_q} + (REM_W+1)'(1);
    diff    = trial - divisor;
    ge      = (trial >= divisor);
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    if (cmd_i.div_start) begin
      dvd_d = clock_q;
      rem_d = '0;
      cnt_d = STEP_CNT_W'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      dvd_d = {dvd_q[RATE_W-2:0], ge};
      rem_d = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt_d = cnt_q - STEP_CNT_W'(1);
    end
  end

  always_comb begin
    shamt = {1'b0, d_q} + (CODE_W+1)'(1);
    rate  = dvd_q >> shamt;
    gap   = target_q - rate;
    take  = (target_q >= rate) && (gap < min_gap_q);
  end

  always_comb begin
    p_d = p_q;
    d_d = d_q;
    if (cmd_i.load) p_d = '0;
    else if (cmd_i.next_p) p_d = p_q + CODE_W'(1);
    if (cmd_i.div_start) d_d = '0;
    else if (cmd_i.scan) d_d = d_q + CODE_W'(1);
  end

  assign sts_o.div_done = (cnt_q == '0);
  assign sts_o.gap_zero = (min_gap_q == '0);
  assign sts_o.d_last   = (d_q == CODE_W'(DivExpMax));
  assign sts_o.p_last   = (p_q == CODE_W'(PrescaleMax));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      p_q   <= '0;
      d_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      p_q   <= p_d;
      d_q   <= d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      clock_q   <= in_data_i.clock_rate;
      target_q  <= in_data_i.target_rate;
      min_gap_q <= GAP_INIT;
      best_p_q  <= CODE_W'(PrescaleMax);
      best_d_q  <= CODE_W'(DivExpMax);
      found_q   <= 1'b0;
    end else if (cmd_i.scan) begin
      last_rate_q <= rate;
      if (take) begin
        min_gap_q   <= gap;
        best_p_q    <= p_q;
        best_d_q    <= d_q;
        best_rate_q <= rate;
        found_q     <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_q.prescaler_code <= best_p_q[2:0];
      out_q.divider_code   <= best_d_q;
      out_q.achieved_rate  <= found_q ? best_rate_q[30:0] : last_rate_q[30:0];
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/spi_baud_divider_search.sv
// ----------------------------------------------------------------------------
// Serial bit-rate divider search
// Finds the prescaler and power-of-two divider closest to a target rate without exceeding it.
// ----------------------------------------------------------------------------
// The input channel carries a source clock rate and a target bit rate; the
// output channel returns the prescaler code, the divider exponent and the
// rate that they give. Both channels use a valid/ready transfer.
// For each prescaler code the block divides the clock by the prescaler with
// a bit-serial divider of one quotient bit per cycle, then scans the divider
// exponents at one per cycle. A full search covers every prescaler code and
// divider exponent; an exact match ends it early. Most of the search time is
// spent in the serial divider.
// One request is searched at a time. The result sits in an output register,
// so a new request is taken while the previous result still waits; if the
// receiver stalls longer, the next search holds at its end until the output
// register is free. Reset returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
module spi_baud_divider_search
  import sbds_pkg::*;
#(
  parameter int unsigned PrescaleMax = PRESCALE_MAX_DEF,
  parameter int unsigned DivExpMax   = DIV_EXP_MAX_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbds_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sbds_out_t out_data_o
);

  sbds_cmd_t cmd;
  sbds_sts_t sts;

  sbds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbds_datapath #(
    .PrescaleMax (PrescaleMax),
    .DivExpMax   (DivExpMax)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

FILE: hw/rtl/sbds_checker.sv
// ----------------------------------------------------------------------------
// Divider search checker
// Port-level assertions for the serial bit-rate divider search block.
// ----------------------------------------------------------------------------
module sbds_checker
  import sbds_pkg::*;
#(
  parameter int unsigned DivExpMax = DIV_EXP_MAX_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input sbds_out_t out_data_o
);

  // A stalled result keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped before its transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // Once a request is taken, the block is busy with its search and takes no further request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("request taken while a search was running");

  // The divider exponent never exceeds the largest one searched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.divider_code) <= DivExpMax))
    else $error("divider exponent out of range");

endmodule

bind spi_baud_divider_search sbds_checker #(
  .DivExpMax (DivExpMax)
) u_sbds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/sbds_result_checker.sv
// ----------------------------------------------------------------------------
// Divider search result checker
// Watches both channels of the divider search block and checks each result.
// ----------------------------------------------------------------------------
// Every request transfer is turned into the expected prescaler code, divider
// exponent and achieved rate by an independent search. These expectations
// wait in order. Each result transfer is compared field by field with the
// oldest one. The checker reports the failure count and the number of
// results still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module sbds_result_checker
  import sbds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  sbds_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  sbds_out_t   out_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned awaited_count_o
);

  sbds_out_t   awaited_settings[$];
  int unsigned mismatches = 0;

  initial begin
    mismatch_count_o = 0;
    awaited_count_o  = 0;
  end

  function automatic logic [31:0] divided_rate(logic [31:0] clock, int unsigned p,
                                               int unsigned d);
    logic [63:0] divisor;
    divisor = 64'(p + 1) << (d + 1);
    return 32'({32'd0, clock} / divisor);
  endfunction

  function automatic sbds_out_t best_baud_setting(sbds_in_t req);
    logic [31:0] best_gap;
    logic [31:0] cand;
    int unsigned best_p;
    int unsigned best_d;
    sbds_out_t   res;
    best_p   = PRESCALE_MAX_DEF;
    best_d   = DIV_EXP_MAX_DEF;
    best_gap = GAP_INIT;
    for (int unsigned p = 0; p <= PRESCALE_MAX_DEF; p++) begin
      for (int unsigned d = 0; d <= DIV_EXP_MAX_DEF; d++) begin
        cand = divided_rate(req.clock_rate, p, d);
        if (best_gap != '0 && req.target_rate >= cand &&
            (req.target_rate - cand) < best_gap) begin
          best_gap = req.target_rate - cand;
          best_p   = p;
          best_d   = d;
        end
      end
    end
    res.prescaler_code = 3'(best_p);
    res.divider_code   = 4'(best_d);
    res.achieved_rate  = 31'(divided_rate(req.clock_rate, best_p, best_d));
    return res;
  endfunction

  always @(posedge clk_i) begin
    sbds_out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_settings.size() == 0) begin
          if (mismatches < 10) begin
            $display("checker: result p=%0d d=%0d rate=%0d with no request pending",
                     out_data_i.prescaler_code, out_data_i.divider_code,
                     out_data_i.achieved_rate);
          end
          mismatches++;
        end else begin
          want = awaited_settings.pop_front();
          if (out_data_i.prescaler_code !== want.prescaler_code ||
              out_data_i.divider_code !== want.divider_code ||
              out_data_i.achieved_rate !== want.achieved_rate) begin
            if (mismatches < 10) begin
              $display("checker: expected p=%0d d=%0d rate=%0d, got p=%0d d=%0d rate=%0d",
                       want.prescaler_code, want.divider_code, want.achieved_rate,
                       out_data_i.prescaler_code, out_data_i.divider_code,
                       out_data_i.achieved_rate);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_settings.push_back(best_baud_setting(in_data_i));
      end
      mismatch_count_o <= mismatches;
      awaited_count_o  <= awaited_settings.size();
    end
  end

endmodule

FILE: tb/tb_spi_baud_divider_search.sv
// ----------------------------------------------------------------------------
// Divider search testbench
// Drives clock and target rate requests into the divider search block.
// ----------------------------------------------------------------------------
// A directed set covers zero and full-scale rates, exact matches, ties and
// targets that no setting can meet. Random requests follow, mostly targets
// close to a real setting of a random clock, in phases with and without idle
// cycles on either side and with one long receiver hold-off. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_spi_baud_divider_search;
  import sbds_pkg::*;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned LongHold    = 2000;
  localparam int unsigned DrainCycles = 400;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        in_valid   = 1'b0;
  sbds_in_t    in_data    = '0;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  sbds_out_t   out_data;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned holds_requested    = 0;
  int unsigned holds_served       = 0;
  int unsigned mismatches;
  int unsigned awaited;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  spi_baud_divider_search u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  sbds_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited)
  );

  task automatic offer_request(input logic [31:0] clock, input logic [31:0] target);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{clock_rate: clock, target_rate: target};
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic sbds_in_t random_request();
    sbds_in_t    req;
    int unsigned kind;
    int unsigned p;
    int unsigned d;
    logic [31:0] near;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3, 4, 5: begin
        req.clock_rate = $urandom_range(1) ? $urandom : $urandom_range(200_000_000, 1_000_000);
        p = $urandom_range(PRESCALE_MAX_DEF);
        d = $urandom_range(DIV_EXP_MAX_DEF);
        near = req.clock_rate / (32'(p + 1) << (d + 1));
        req.target_rate = near + $urandom_range(4) - 2;
      end
      6, 7: begin
        req.clock_rate  = $urandom;
        req.target_rate = $urandom;
      end
      8: begin
        req.clock_rate  = $urandom_range(5000);
        req.target_rate = $urandom_range(300);
      end
      default: begin
        case ($urandom_range(2))
          0:       req.clock_rate = '0;
          1:       req.clock_rate = '1;
          default: req.clock_rate = $urandom;
        endcase
        case ($urandom_range(2))
          0:       req.target_rate = '0;
          1:       req.target_rate = '1;
          default: req.target_rate = 32'h7FFF_FFFF;
        endcase
      end
    endcase
    return req;
  endfunction

  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_requested) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      out_ready <= !(receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct);
    end
  end

  initial begin
    sbds_in_t req;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_request(32'd0, 32'd0);
    offer_request(32'd0, 32'hFFFF_FFFF);
    offer_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(32'hFFFF_FFFF, 32'd0);
    offer_request(32'd1, 32'hFFFF_FFFF);
    offer_request(32'd1, 32'd0);
    offer_request(32'd48_000_000, 32'd1_000_000);
    offer_request(32'd100_000_000, 32'd9_600);
    offer_request(32'd96, 32'd12);
    offer_request(32'd1000, 32'd130);
    offer_request(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer_request(32'hFFFF_FFFF, 32'h7FFF_FFFE);
    offer_request(32'h8000_0000, 32'd1);
    offer_request(32'd20480, 32'd5);
    offer_request(32'd4095, 32'd0);
    offer_request(32'h5555_5555, 32'hAAAA_AAAA);
    offer_request(32'hAAAA_AAAA, 32'h5555_5555);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          holds_requested++;
        end
        1: begin
          sender_idle_pct    = 75;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 75;
        end
        default: begin
          sender_idle_pct    = 8;
          receiver_stall_pct = 8;
        end
      endcase
      for (int n = 0; n < RandomItems / 4; n++) begin
        req = random_request();
        offer_request(req.clock_rate, req.target_rate);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
